[design/point_in_polygon_inclusive_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the point-in-polygon block
// Every macro samples on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_INCLUSIVE_MACROS_SVH
`define POINT_IN_POLYGON_INCLUSIVE_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define PIP_ASSERT_IMPL(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define PIP_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

[design/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants and control structs of the point-in-polygon block.
// ----------------------------------------------------------------------------
package pip_pkg;

  // fixed widths of the channel payloads and the count register
  localparam int PORT_COORD_W = 32;
  localparam int PORT_INDEX_W = 4;
  localparam int VC_W         = 5;

  // smallest polygon; smaller counts act as this
  localparam int MIN_VERTICES = 3;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // tag that rides with an edge through the edge pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } edge_tag_t;

  // per-edge verdict leaving the edge pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic on_edge;
    logic flip;
  } edge_flags_t;

endpackage

[design/pip_if.sv]
// ----------------------------------------------------------------------------
// pip_if
// Valid/ready channels of the point-in-polygon block: command and result.
// ----------------------------------------------------------------------------
interface pip_in_if;
  import pip_pkg::*;

  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [PORT_INDEX_W-1:0]        vertex_index;
  logic signed [PORT_COORD_W-1:0] coord_x;
  logic signed [PORT_COORD_W-1:0] coord_y;

  modport source (output valid, action, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, action, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic on_boundary;

  modport source (output valid, inside_res, on_boundary, input ready);
  modport sink   (input valid, inside_res, on_boundary, output ready);
endinterface

[design/pip_front.sv]
// ----------------------------------------------------------------------------
// pip_front
// Accept commands, classify them, narrow the coordinates and hand them on.
// ----------------------------------------------------------------------------
module pip_front #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 32,
  localparam int AW    = $clog2(MAX_VERTICES),
  localparam int CMD_W = 1 + AW + 2 * COORD_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  pip_in_if.sink           cmd,
  output logic             push_valid,
  input  logic             push_ready,
  output logic [CMD_W-1:0] push_data
);
  import pip_pkg::*;

  typedef struct packed {
    logic                          query;
    logic [AW-1:0]                 slot;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } cmd_t;

  logic hold_valid;
  cmd_t hold_cmd;
  cmd_t cmd_next;
  logic keep;
  logic take;

  assign cmd.ready = !hold_valid || push_ready;
  assign take      = cmd.valid && cmd.ready;

  // drop writes to slots the store does not have
  assign keep = (cmd.action == ACT_QUERY) ||
                (32'(cmd.vertex_index) < 32'(MAX_VERTICES));

  always_comb begin
    cmd_next.query = (cmd.action == ACT_QUERY);
    cmd_next.slot  = AW'(cmd.vertex_index);
    cmd_next.x     = cmd.coord_x[COORD_WIDTH-1:0];
    cmd_next.y     = cmd.coord_y[COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= keep;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_cmd <= cmd_next;
    end
  end

  assign push_valid = hold_valid;
  assign push_data  = hold_cmd;

endmodule

[design/pip_queue.sv]
// ----------------------------------------------------------------------------
// pip_queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`include "point_in_polygon_inclusive_macros.svh"

module pip_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW   = $clog2(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count != CNTW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push_fire, pop_fire})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `PIP_ASSERT_IMPL(a_empty_ptrs_meet, count == '0, wr_ptr == rd_ptr, "queue empty but pointers differ")

endmodule

[design/pip_edge.sv]
// ----------------------------------------------------------------------------
// pip_edge
// Four-stage edge unit: exact on-edge and ray-crossing verdict for one edge.
// ----------------------------------------------------------------------------
module pip_edge #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pip_pkg::edge_tag_t            tag_in,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  output pip_pkg::edge_flags_t          flags_out
);
  import pip_pkg::*;

  localparam int D = COORD_WIDTH + 1;  // difference
  localparam int P = 2 * D;            // product
  localparam int S = P + 2;            // sums and their difference

  edge_tag_t tag1, tag2, tag3;

  // stage 1: differences
  logic signed [D-1:0] ex, ey, qx, qy;
  logic                a_above1, b_above1;

  // stage 2: products
  logic signed [P-1:0] m_exqy, m_eyqx, m_qxex, m_qyey, m_exex, m_eyey;
  logic                degen2, qzero2, straddle2, b_above2;

  // stage 3: sums
  logic signed [S-1:0] xprod, proj, len2;
  logic                degen3, qzero3, straddle3, b_above3;

  logic signed [S-1:0] gap;
  logic                on_now;
  logic                flip_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1      <= '0;
      tag2      <= '0;
      tag3      <= '0;
      flags_out <= '0;
    end else begin
      tag1                <= tag_in;
      tag2                <= tag1;
      tag3                <= tag2;
      flags_out.valid     <= tag3.valid;
      flags_out.last      <= tag3.last;
      flags_out.on_edge   <= on_now;
      flags_out.flip      <= flip_now;
    end
  end

  always_ff @(posedge clk) begin
    ex       <= $signed({bx[COORD_WIDTH-1], bx}) - $signed({ax[COORD_WIDTH-1], ax});
    ey       <= $signed({by[COORD_WIDTH-1], by}) - $signed({ay[COORD_WIDTH-1], ay});
    qx       <= $signed({px[COORD_WIDTH-1], px}) - $signed({ax[COORD_WIDTH-1], ax});
    qy       <= $signed({py[COORD_WIDTH-1], py}) - $signed({ay[COORD_WIDTH-1], ay});
    a_above1 <= (ay > py);
    b_above1 <= (by > py);

    m_exqy    <= P'(ex) * P'(qy);
    m_eyqx    <= P'(ey) * P'(qx);
    m_qxex    <= P'(qx) * P'(ex);
    m_qyey    <= P'(qy) * P'(ey);
    m_exex    <= P'(ex) * P'(ex);
    m_eyey    <= P'(ey) * P'(ey);
    degen2    <= (ex == '0) && (ey == '0);
    qzero2    <= (qx == '0) && (qy == '0);
    straddle2 <= (a_above1 != b_above1);
    b_above2  <= b_above1;

    xprod     <= S'(m_exqy) - S'(m_eyqx);
    proj      <= S'(m_qxex) + S'(m_qyey);
    len2      <= S'(m_exex) + S'(m_eyey);
    degen3    <= degen2;
    qzero3    <= qzero2;
    straddle3 <= straddle2;
    b_above3  <= b_above2;
  end

  // stage 4: verdicts
  assign gap = len2 - proj;

  // a zero-length edge holds only its own endpoint
  assign on_now = degen3 ? qzero3
                         : ((xprod == '0) && !proj[S-1] && !gap[S-1]);

  // crossing lies right of the point when the cross product sign matches the
  // edge direction in y; horizontal edges never straddle
  assign flip_now = straddle3 && (xprod != '0) && (!xprod[S-1] == b_above3);

endmodule

[design/pip_back.sv]
// ----------------------------------------------------------------------------
// pip_back
// Vertex store, edge walk sequencer, result accumulation and output register.
// ----------------------------------------------------------------------------
`include "point_in_polygon_inclusive_macros.svh"

module pip_back #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 32,
  localparam int AW    = $clog2(MAX_VERTICES),
  localparam int CW    = $clog2(MAX_VERTICES + 1),
  localparam int CMD_W = 1 + AW + 2 * COORD_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [pip_pkg::VC_W-1:0] vertex_count,
  input  logic                     pop_valid,
  output logic                     pop_ready,
  input  logic [CMD_W-1:0]         pop_data,
  pip_out_if.source                res
);
  import pip_pkg::*;

  localparam int NW = (CW > VC_W) ? CW : VC_W;

  typedef struct packed {
    logic                          query;
    logic [AW-1:0]                 slot;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;
  cmd_t   cmd;
  logic   pop_fire;

  logic [NW-1:0] vc_ext;
  logic [CW-1:0] n_clamp;
  logic [CW-1:0] n_q;
  logic [CW-1:0] rd_cnt;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] rd_x, rd_y, prev_x, prev_y, px_q, py_q;
  logic                          rv, r_first, r_last;

  edge_tag_t   tag;
  edge_flags_t flags;

  logic acc_on, acc_par;
  logic out_valid, out_inside, out_bnd;
  logic out_free;

  assign cmd       = cmd_t'(pop_data);
  assign pop_ready = (state == ST_IDLE);
  assign pop_fire  = pop_valid && pop_ready;
  assign mem_we    = pop_fire && !cmd.query;
  assign rd_en     = (state == ST_WALK);
  assign rd_addr   = (rd_cnt == n_q) ? '0 : rd_cnt[AW-1:0];
  assign out_free  = !out_valid || res.ready;

  // clamp the vertex count into the store's range
  assign vc_ext = NW'(vertex_count);
  always_comb begin
    if (vc_ext < NW'(MIN_VERTICES)) begin
      n_clamp = CW'(MIN_VERTICES);
    end else if (vc_ext > NW'(MAX_VERTICES)) begin
      n_clamp = CW'(MAX_VERTICES);
    end else begin
      n_clamp = CW'(vc_ext);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop_fire && cmd.query) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_cnt == n_q) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (flags.valid && flags.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= rd_en;
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // query setup, read walk and accumulation
  always_ff @(posedge clk) begin
    if (pop_fire && cmd.query) begin
      px_q    <= cmd.x;
      py_q    <= cmd.y;
      n_q     <= n_clamp;
      rd_cnt  <= '0;
      acc_on  <= 1'b0;
      acc_par <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_cnt <= rd_cnt + CW'(1);
      end
      if (flags.valid) begin
        acc_on  <= acc_on | flags.on_edge;
        acc_par <= acc_par ^ flags.flip;
      end
    end
    if (rd_en) begin
      r_first <= (rd_cnt == '0);
      r_last  <= (rd_cnt == n_q);
    end
    if (rv) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
    if (state == ST_FINISH && out_free) begin
      out_inside <= acc_on | acc_par;
      out_bnd    <= acc_on;
    end
  end

  // vertex store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[cmd.slot] <= cmd.x;
      mem_y[cmd.slot] <= cmd.y;
    end
    if (rd_en) begin
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
    end
  end

  // edge from the previous vertex to the one just read
  assign tag.valid = rv && !r_first;
  assign tag.last  = r_last;

  pip_edge #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_edge (
    .clk       (clk),
    .rst       (rst),
    .tag_in    (tag),
    .ax        (prev_x),
    .ay        (prev_y),
    .bx        (rd_x),
    .by        (rd_y),
    .px        (px_q),
    .py        (py_q),
    .flags_out (flags)
  );

  assign res.valid       = out_valid;
  assign res.inside_res  = out_inside;
  assign res.on_boundary = out_bnd;

  `PIP_ASSERT_IMPL(a_walk_in_range, state == ST_WALK, rd_cnt <= n_q, "read walk ran past the last vertex")
  `PIP_ASSERT_IMPL(a_flags_in_query, flags.valid, state == ST_WALK || state == ST_DRAIN, "edge verdict outside a query")
  `PIP_ASSERT_IMPL(a_result_from_finish, $rose(out_valid), $past(state == ST_FINISH), "result raised without a finished query")

endmodule

[design/point_in_polygon_inclusive.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_inclusive
// Inclusive point-in-polygon test with a writable vertex store. A command with
// action write stores one vertex in the slot vertex_index (writes to slots at
// or beyond MAX_VERTICES are dropped) and returns nothing. A command with
// action query returns one result: on_boundary is set when the point is on any
// edge, collinear and within its span, and inside_res is then set too;
// otherwise inside_res is the parity of horizontal-ray crossings. All edge
// math is exact. The polygon is the first vertex_count slots (clamped to
// 3..MAX_VERTICES) closing back to slot zero; write vertex_count only while
// the block is idle. A vertex write leaves the back end in its idle state,
// free for the next command; a query holds it through the walk that reads
// one vertex per cycle from the single read port of the vertex store, the
// four-stage edge unit behind it and the drain and finish states. A
// two-entry queue lets the front take further commands while a query runs,
// and the result register lets the next command start while a result waits.
// The vertex store has no reset; read only slots that were written.
// ----------------------------------------------------------------------------
module point_in_polygon_inclusive #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic [pip_pkg::VC_W-1:0] cfg_wdata,
  pip_in_if.sink                   cmd,
  pip_out_if.source                res
);
  import pip_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CMD_W = 1 + AW + 2 * COORD_WIDTH;

  logic [VC_W-1:0]  vertex_count;
  logic             push_valid, push_ready;
  logic [CMD_W-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [CMD_W-1:0] pop_data;

  // vertex count register; hold until the next write
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_W'(MIN_VERTICES);
    end else if (cfg_wen) begin
      vertex_count <= cfg_wdata;
    end
  end

  // front: accept each transfer, drop out-of-range writes, narrow coordinates
  pip_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // queue: let front and back stall independently
  pip_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: write the store, or walk every edge and deliver one result
  pip_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .vertex_count (vertex_count),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .res          (res)
  );

endmodule
